>>> rtl/iie_pkg.sv
package iie_pkg;

  localparam int VALUE_WIDTH = 32;

  // Largest literal magnitude that can still be legal (with an inner minus).
  localparam logic [VALUE_WIDTH:0] VSIGN = (VALUE_WIDTH + 1)'(1) << (VALUE_WIDTH - 1);
  // Saturation value of the literal accumulator.
  localparam logic [VALUE_WIDTH:0] VSAT  = VSIGN + (VALUE_WIDTH + 1)'(1);

  // Largest accumulator value that may still take digit d without passing VSIGN.
  localparam logic [VALUE_WIDTH:0] DIGIT_LIMIT [10] = '{
    (VSIGN - 0) / 10, (VSIGN - 1) / 10, (VSIGN - 2) / 10, (VSIGN - 3) / 10,
    (VSIGN - 4) / 10, (VSIGN - 5) / 10, (VSIGN - 6) / 10, (VSIGN - 7) / 10,
    (VSIGN - 8) / 10, (VSIGN - 9) / 10
  };

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MUL  = 3'd1,
    OP_DIV  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4
  } op_t;

  // One command from the parser to the arithmetic unit, applied in field order:
  // literal, then operator, then end of expression.
  typedef struct packed {
    logic                   has_num;
    logic [VALUE_WIDTH-1:0] num;
    op_t                    op;
    logic                   is_end;
    logic                   ok;
  } cmd_t;

endpackage

>>> rtl/iie_front.sv
module iie_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    character,
  input  logic          last,
  input  logic          char_valid,
  output logic          char_ready,
  output iie_pkg::cmd_t cmd,
  output logic          cmd_push,
  input  logic          queue_full
);
  import iie_pkg::*;

  typedef enum logic [4:0] {
    PH_SIGN1  = 5'b00001,
    PH_SIGN2  = 5'b00010,
    PH_INNER  = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_OP     = 5'b10000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [VALUE_WIDTH:0]   nv, nv_next;
  logic                   outer, outer_next;
  logic                   inner, inner_next;
  logic                   err, err_next;
  logic                   blank, digit, sign, mulop;
  logic [3:0]             d;

  function automatic logic num_ovf(input logic [VALUE_WIDTH:0] m, input logic neg_in);
    return (m > VSIGN) || (m == VSIGN && !neg_in);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] num_val(input logic [VALUE_WIDTH:0] m,
                                                     input logic in_neg, input logic out_neg);
    logic [VALUE_WIDTH-1:0] v;
    v = in_neg ? -m[VALUE_WIDTH-1:0] : m[VALUE_WIDTH-1:0];
    return out_neg ? -v : v;
  endfunction

  assign blank = (character == CH_SPACE) || (character >= CH_TAB && character <= CH_CR);
  assign digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign sign  = (character == CH_PLUS) || (character == CH_MINUS);
  assign mulop = (character == CH_STAR) || (character == CH_SLASH);
  assign d     = character[3:0];

  assign char_ready = !queue_full;

  always_comb begin
    logic do_op;
    phase_next = phase;
    nv_next    = nv;
    outer_next = outer;
    inner_next = inner;
    err_next   = err;
    do_op      = 1'b0;
    cmd        = '0;
    cmd.op     = OP_NONE;
    if (!err) begin
      case (phase)
        PH_SIGN1, PH_SIGN2: begin
          if (blank) begin
          end else if (digit) begin
            phase_next = PH_DIGITS;
          end else if (sign && phase == PH_SIGN1) begin
            outer_next = (character == CH_MINUS);
            phase_next = PH_SIGN2;
          end else if (sign) begin
            inner_next = (character == CH_MINUS);
            phase_next = PH_INNER;
          end else begin
            err_next = 1'b1;
          end
        end
        PH_INNER: begin
          if (digit) phase_next = PH_DIGITS;
          else err_next = 1'b1;
        end
        PH_DIGITS: begin
          if (digit) begin
          end else if (!(blank || sign || mulop)) begin
            err_next = 1'b1;
          end else if (num_ovf(nv, inner)) begin
            err_next = 1'b1;
          end else begin
            cmd.has_num = 1'b1;
            cmd.num     = num_val(nv, inner, outer);
            phase_next  = PH_OP;
            do_op       = !blank;
          end
        end
        PH_OP: begin
          if (blank) begin
          end else if (!(sign || mulop)) begin
            err_next = 1'b1;
          end else begin
            do_op = 1'b1;
          end
        end
        default: err_next = 1'b1;
      endcase
      // accumulate a digit, saturating past the legal range
      if (digit && phase != PH_OP) begin
        if (nv > VSIGN || nv > DIGIT_LIMIT[d])
          nv_next = VSAT;
        else
          nv_next = (nv << 3) + (nv << 1) + (VALUE_WIDTH + 1)'(d);
      end
    end
    if (do_op) begin
      if (character == CH_STAR)       cmd.op = OP_MUL;
      else if (character == CH_SLASH) cmd.op = OP_DIV;
      else if (character == CH_MINUS) cmd.op = OP_SUB;
      else                            cmd.op = OP_ADD;
      phase_next = PH_SIGN1;
      nv_next    = '0;
      outer_next = 1'b0;
      inner_next = 1'b0;
    end
    if (last) begin
      if (!err_next && phase_next == PH_DIGITS) begin
        if (num_ovf(nv_next, inner_next)) begin
          err_next = 1'b1;
        end else begin
          cmd.has_num = 1'b1;
          cmd.num     = num_val(nv_next, inner_next, outer_next);
          phase_next  = PH_OP;
        end
      end
      cmd.is_end = 1'b1;
      cmd.ok     = !err_next && phase_next == PH_OP;
      phase_next = PH_SIGN1;
      nv_next    = '0;
      outer_next = 1'b0;
      inner_next = 1'b0;
      err_next   = 1'b0;
    end
  end

  assign cmd_push = char_valid && char_ready &&
                    (cmd.has_num || cmd.op != OP_NONE || cmd.is_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIGN1;
      nv    <= '0;
      outer <= 1'b0;
      inner <= 1'b0;
      err   <= 1'b0;
    end else if (char_valid && char_ready) begin
      phase <= phase_next;
      nv    <= nv_next;
      outer <= outer_next;
      inner <= inner_next;
      err   <= err_next;
    end
  end

endmodule

>>> rtl/iie_queue.sv
module iie_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  iie_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output iie_pkg::cmd_t cmd_out,
  output logic          empty
);
  import iie_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign cmd_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

>>> rtl/iie_back.sv
module iie_back (
  input  logic                               clk,
  input  logic                               rst,
  input  iie_pkg::cmd_t                      cmd,
  input  logic                               empty,
  output logic                               pop,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [iie_pkg::VALUE_WIDTH-1:0] value,
  output logic                               error
);
  import iie_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_NUM  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SIGN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                 state;
  cmd_t                   cur;
  logic [VALUE_WIDTH-1:0] sum, prod;
  logic                   add_neg;
  op_t                    mop;
  logic                   err;
  logic [VALUE_WIDTH-1:0] div_q, div_b;
  logic [VALUE_WIDTH:0]   div_r;
  logic [CNT_W-1:0]       div_cnt;
  logic                   div_neg;
  logic [VALUE_WIDTH:0]   rem_sh, diff;
  logic [VALUE_WIDTH-1:0] sum_closed;

  assign pop        = (state == S_IDLE) && !empty;
  assign rem_sh     = {div_r[VALUE_WIDTH-1:0], div_q[VALUE_WIDTH-1]};
  assign diff       = rem_sh - {1'b0, div_b};
  assign sum_closed = add_neg ? sum - prod : sum + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sum          <= '0;
      prod         <= '0;
      add_neg      <= 1'b0;
      mop          <= OP_NONE;
      err          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // drop the result after its transfer unless a new one replaces it
      if (result_valid && result_ready && !(state == S_FIN && cur.is_end))
        result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cur   <= cmd;
            state <= S_NUM;
          end
        end
        S_NUM: begin
          if (err || !cur.has_num) begin
            state <= S_FIN;
          end else begin
            case (mop)
              OP_MUL: begin
                prod  <= prod * cur.num;
                state <= S_FIN;
              end
              OP_DIV: begin
                if (cur.num == '0) begin
                  err   <= 1'b1;
                  state <= S_FIN;
                end else begin
                  div_q   <= prod[VALUE_WIDTH-1] ? -prod : prod;
                  div_b   <= cur.num[VALUE_WIDTH-1] ? -cur.num : cur.num;
                  div_r   <= '0;
                  div_cnt <= '0;
                  div_neg <= prod[VALUE_WIDTH-1] ^ cur.num[VALUE_WIDTH-1];
                  state   <= S_DIV;
                end
              end
              default: begin
                prod  <= cur.num;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_DIV: begin
          // restoring division: one quotient bit per cycle
          div_r   <= diff[VALUE_WIDTH] ? rem_sh : diff;
          div_q   <= {div_q[VALUE_WIDTH-2:0], !diff[VALUE_WIDTH]};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(VALUE_WIDTH - 1)) state <= S_SIGN;
        end
        S_SIGN: begin
          prod  <= div_neg ? -div_q : div_q;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!(cur.is_end && result_valid && !result_ready)) begin
            if (!err && !cur.is_end) begin
              case (cur.op)
                OP_MUL, OP_DIV: mop <= cur.op;
                OP_ADD, OP_SUB: begin
                  sum     <= sum_closed;
                  add_neg <= (cur.op == OP_SUB);
                  mop     <= OP_NONE;
                end
                default: ;
              endcase
            end
            if (cur.is_end) begin
              result_valid <= 1'b1;
              error        <= !(cur.ok && !err);
              value        <= (cur.ok && !err) ? sum_closed : '0;
              sum          <= '0;
              prod         <= '0;
              add_neg      <= 1'b0;
              mop          <= OP_NONE;
              err          <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_b != '0) else $error("divider running with zero divisor");
  a_sign_after_div: assert property (@(posedge clk) disable iff (rst)
    state == S_SIGN |-> $past(state == S_DIV)) else $error("quotient fixup out of order");
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && error |-> value == '0) else $error("error result carries a value");
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FIN)) else $error("result raised outside finish");

endmodule

>>> rtl/infix_integer_expression_evaluator.sv
// Infix integer expression evaluator. Feed the expression one ASCII character per
// transfer on the character channel and mark its final character with last; one
// result (value, error) follows on the result channel for every expression. Decimal
// literals, + - * / with the usual precedence, left to right, no parentheses; blanks
// are skipped and a literal may carry an outer sign and an inner sign placed against
// its digits. Arithmetic wraps at 32 bits and division truncates toward zero. error is
// 1 (with value 0) for a malformed expression, a stray character, an empty input, a
// literal that does not fit 32 bits, or division by zero. A parser front end takes one
// character per cycle and posts literals and operators into a four-entry command
// queue; the arithmetic back end works through one command at a time, and a command
// that divides runs its restoring divider, which produces one quotient bit per cycle.
// Intake stalls only when the queue fills, so plain text runs at about one character
// per cycle in bursts and at the back end's pace sustained.
module infix_integer_expression_evaluator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [7:0]                             character,
  input  logic                                   last,
  input  logic                                   char_valid,
  output logic                                   char_ready,
  output logic signed [iie_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   error,
  output logic                                   result_valid,
  input  logic                                   result_ready
);
  import iie_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  // parse and classify characters, build literals
  iie_front u_front (
    .clk        (clk),
    .rst        (rst),
    .character  (character),
    .last       (last),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .cmd        (push_cmd),
    .cmd_push   (push),
    .queue_full (full)
  );

  // hold commands so parsing and arithmetic stall independently
  iie_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (push_cmd),
    .full    (full),
    .pop     (pop),
    .cmd_out (pop_cmd),
    .empty   (empty)
  );

  // running sum and product, divider, result register
  iie_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (pop_cmd),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value        (value),
    .error        (error)
  );

endmodule
